// ===== src/ftrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ftrt_pkg
// Shared types, request and status codes, and beat widths of the five-tuple
// rule table.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrt_pkg;

	localparam int DEF_RULE_SLOTS = 32;

	localparam int REQ_W        = 2;
	localparam int LIMIT_W      = 6;
	localparam int COUNT_OUT_W  = 6;
	localparam int STATUS_W     = 2;
	localparam int S_TDATA_W    = 112;
	localparam int M_TDATA_W    = 112;

	localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LIST = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [7:0]  protocol;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [COUNT_OUT_W-1:0] rule_count;
		logic                   entry_valid;
		rule_t                  rule;
		logic                   last;
	} beat_t;

endpackage

`default_nettype wire

// ===== src/five_tuple_rule_table.sv =====
// ----------------------------------------------------------------------------
// five_tuple_rule_table
// Exact-match five-tuple rule table with add, delete and list requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Add and delete compare the stored
// rules one slot per cycle through the single read port of the rule memory;
// a delete that hits then reads the last rule and writes it into the freed
// slot. A list streams one rule per cycle while the output is taken. Every
// request gives its result beats in order, the final one marked by m_tlast,
// and a new request is accepted as soon as the last beat sits in the output
// register. Reset empties the table at once; the memory needs no clearing
// pass.
`default_nettype none

module five_tuple_rule_table
	import ftrt_pkg::*;
#(
	parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// source address, destination address, source port, destination port,
	// protocol, list limit, zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// req_type
	input  wire logic [REQ_W-1:0]     s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// status, rule count, listed source address, destination address,
	// source port, destination port, protocol
	output logic [M_TDATA_W-1:0]      m_tdata,
	// entry_valid
	output logic                      m_tuser,
	output logic                      m_tlast
);

	localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

	rule_t              in_rule;
	logic [LIMIT_W-1:0] in_limit;
	logic               out_free;
	logic               beat_valid;
	beat_t              beat;
	logic               out_valid_q;
	beat_t              out_beat_q;

	logic               ram_wr_en;
	logic [IDX_W-1:0]   ram_wr_addr;
	rule_t              ram_wr_data;
	logic               ram_rd_en;
	logic [IDX_W-1:0]   ram_rd_addr;
	logic [RULE_W-1:0]  ram_rd_bits;

	assign in_rule.src_addr = s_tdata[31:0];
	assign in_rule.dst_addr = s_tdata[63:32];
	assign in_rule.sport    = s_tdata[79:64];
	assign in_rule.dport    = s_tdata[95:80];
	assign in_rule.protocol = s_tdata[103:96];
	assign in_limit         = s_tdata[109:104];

	ftrt_engine #(
		.RULE_SLOTS (RULE_SLOTS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_req_type (s_tuser),
		.in_rule     (in_rule),
		.in_limit    (in_limit),
		.out_free    (out_free),
		.beat_valid  (beat_valid),
		.beat        (beat),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (rule_t'(ram_rd_bits))
	);

	ftrt_ram #(
		.WIDTH (RULE_W),
		.DEPTH (RULE_SLOTS)
	) u_rule_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (RULE_W'(ram_wr_data)),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_bits)
	);

	// The output register frees up in the same cycle its beat is taken.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_valid) begin
			out_beat_q <= beat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_beat_q.entry_valid;
	assign m_tlast  = out_beat_q.last;
	assign m_tdata  = {out_beat_q.rule.protocol,
	                   out_beat_q.rule.dport,
	                   out_beat_q.rule.sport,
	                   out_beat_q.rule.dst_addr,
	                   out_beat_q.rule.src_addr,
	                   out_beat_q.rule_count,
	                   out_beat_q.status};

endmodule

`default_nettype wire

// ===== src/ftrt_ram.sv =====
// ----------------------------------------------------------------------------
// ftrt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                        clk,
	input  wire logic                                        wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// The read data holds until the next read.
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ftrt_engine.sv =====
// ----------------------------------------------------------------------------
// ftrt_engine
// Request sequencer: scans the rule memory, appends, moves the tail rule
// into a freed slot and streams listed rules toward the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrt_engine
	import ftrt_pkg::*;
#(
	parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              in_valid,
	output logic                                                   in_ready,
	input  wire logic [REQ_W-1:0]                                  in_req_type,
	input  wire rule_t                                             in_rule,
	input  wire logic [LIMIT_W-1:0]                                in_limit,
	input  wire logic                                              out_free,
	output logic                                                   beat_valid,
	output beat_t                                                  beat,
	output logic                                                   ram_wr_en,
	output logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] ram_wr_addr,
	output rule_t                                                  ram_wr_data,
	output logic                                                   ram_rd_en,
	output logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] ram_rd_addr,
	input  wire rule_t                                             ram_rd_data
);

	localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W = $clog2(RULE_SLOTS + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_TAIL_RD = 3'd2;
	localparam logic [2:0] ST_TAIL_WR = 3'd3;
	localparam logic [2:0] ST_LIST    = 3'd4;
	localparam logic [2:0] ST_RESP    = 3'd5;

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	rule_t               key_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    n_q;
	logic [IDX_W-1:0]    found_q;
	logic [STATUS_W-1:0] status_q;
	logic                pend_q;
	logic                issue_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                in_fire;
	logic                scan_issue;
	logic                hit;
	logic                miss;
	logic                full;
	logic                list_emit;
	logic                list_issue;
	logic [CNT_W-1:0]    tail_cnt;
	logic [CMP_W-1:0]    cnt_wide;
	logic [CMP_W-1:0]    limit_wide;
	logic [CNT_W-1:0]    n_in;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign full       = (count_q == CNT_W'(RULE_SLOTS));
	assign tail_cnt   = count_q - CNT_W'(1);
	assign cnt_wide   = CMP_W'(count_q);
	assign limit_wide = CMP_W'(in_limit);
	// The limit only wins when it is not above the count, so it fits the count width.
	assign n_in       = (cnt_wide < limit_wide) ? count_q : CNT_W'(limit_wide);

	assign scan_issue = (state_q == ST_SCAN) && (idx_q < count_q);
	assign hit        = (state_q == ST_SCAN) && issue_s1 && (ram_rd_data == key_q);
	// A miss is known once every stored slot has been compared.
	assign miss       = (state_q == ST_SCAN) && !issue_s1 && (idx_q == count_q);

	assign list_emit  = (state_q == ST_LIST) && pend_q && out_free;
	assign list_issue = (state_q == ST_LIST) && (!pend_q || list_emit) && (idx_q < n_q);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q[IDX_W-1:0];
		ram_wr_en   = 1'b0;
		ram_wr_addr = count_q[IDX_W-1:0];
		ram_wr_data = key_q;
		beat_valid  = 1'b0;
		beat        = '0;
		beat.rule_count = cnt_wide[COUNT_OUT_W-1:0];
		case (state_q)
			ST_SCAN: begin
				ram_rd_en = scan_issue;
				if (!hit && miss && (req_q == REQ_ADD) && !full) begin
					ram_wr_en = 1'b1;
				end
			end
			ST_TAIL_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = tail_cnt[IDX_W-1:0];
			end
			ST_TAIL_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = found_q;
				ram_wr_data = ram_rd_data;
			end
			ST_LIST: begin
				ram_rd_en        = list_issue;
				beat_valid       = list_emit;
				beat.status      = STAT_OK;
				beat.entry_valid = 1'b1;
				beat.rule        = ram_rd_data;
				beat.last        = (idx_q == n_q);
			end
			ST_RESP: begin
				beat_valid  = out_free;
				beat.status = status_q;
				beat.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			count_q  <= '0;
			n_q      <= '0;
			found_q  <= '0;
			status_q <= STAT_OK;
			pend_q   <= 1'b0;
			issue_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						req_q    <= in_req_type;
						key_q    <= in_rule;
						idx_q    <= '0;
						issue_s1 <= 1'b0;
						pend_q   <= 1'b0;
						status_q <= STAT_OK;
						n_q      <= n_in;
						case (in_req_type)
							REQ_ADD, REQ_DEL: begin
								state_q <= ST_SCAN;
							end
							REQ_LIST: begin
								state_q <= (n_in == '0) ? ST_RESP : ST_LIST;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					issue_s1 <= scan_issue;
					idx_s1   <= idx_q[IDX_W-1:0];
					if (scan_issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= idx_s1;
						if (req_q == REQ_ADD) begin
							status_q <= STAT_DUPLICATE;
							state_q  <= ST_RESP;
						end else begin
							state_q <= ST_TAIL_RD;
						end
					end else if (miss) begin
						state_q <= ST_RESP;
						if (req_q == REQ_ADD) begin
							if (full) begin
								status_q <= STAT_FULL;
							end else begin
								status_q <= STAT_OK;
								count_q  <= count_q + CNT_W'(1);
							end
						end else begin
							status_q <= STAT_NOT_FOUND;
						end
					end
				end
				ST_TAIL_RD: begin
					state_q <= ST_TAIL_WR;
				end
				ST_TAIL_WR: begin
					count_q  <= tail_cnt;
					status_q <= STAT_OK;
					state_q  <= ST_RESP;
				end
				ST_LIST: begin
					if (list_issue) begin
						idx_q  <= idx_q + CNT_W'(1);
						pend_q <= 1'b1;
					end else if (list_emit) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/five_tuple_rule_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// five_tuple_rule_table_checker
// Watches both streams of the rule table, keeps its own copy of the table,
// works out the beats that each accepted request must give and compares
// every returned beat with the oldest one still owed.
// ----------------------------------------------------------------------------

module five_tuple_rule_table_checker
	import ftrt_pkg::*;
#(
	parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// source address, destination address, source port, destination port,
	// protocol, list limit, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic [REQ_W-1:0]     s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// status, rule count, listed source address, destination address,
	// source port, destination port, protocol
	input  logic [M_TDATA_W-1:0] m_tdata,
	// entry_valid
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   replies_owed,
	output int                   requests_seen,
	output int                   beats_seen,
	output int                   rules_listed,
	output int                   dup_adds,
	output int                   full_adds,
	output int                   missed_deletes,
	output int                   peak_rules
);

	rule_t slot_rule [RULE_SLOTS];
	int    held;
	beat_t replies_due [$];

	task automatic owe_beat(input logic [STATUS_W-1:0] status, input logic entry_valid,
			input rule_t r, input logic last);
		beat_t b;
		b.status      = status;
		b.rule_count  = held[COUNT_OUT_W-1:0];
		b.entry_valid = entry_valid;
		b.rule        = r;
		b.last        = last;
		replies_due.push_back(b);
	endtask

	// Applies one request to the shadow table and queues the beats it owes.
	task automatic predict_reply(input logic [REQ_W-1:0] kind, input rule_t r,
			input logic [LIMIT_W-1:0] lim);
		int hit;
		int n;
		hit = -1;
		for (int i = 0; i < held; i++) begin
			if (hit < 0 && slot_rule[i] == r)
				hit = i;
		end
		case (kind)
			REQ_ADD: begin
				// A duplicate is reported ahead of a full table.
				if (hit >= 0) begin
					dup_adds++;
					owe_beat(STAT_DUPLICATE, 1'b0, '0, 1'b1);
				end else if (held >= RULE_SLOTS) begin
					full_adds++;
					owe_beat(STAT_FULL, 1'b0, '0, 1'b1);
				end else begin
					slot_rule[held] = r;
					held++;
					owe_beat(STAT_OK, 1'b0, '0, 1'b1);
				end
			end
			REQ_DEL: begin
				if (hit < 0) begin
					missed_deletes++;
					owe_beat(STAT_NOT_FOUND, 1'b0, '0, 1'b1);
				end else begin
					// The last stored rule fills the freed slot.
					slot_rule[hit] = slot_rule[held-1];
					held--;
					owe_beat(STAT_OK, 1'b0, '0, 1'b1);
				end
			end
			REQ_LIST: begin
				n = (held < int'(lim)) ? held : int'(lim);
				if (n == 0) begin
					owe_beat(STAT_OK, 1'b0, '0, 1'b1);
				end else begin
					for (int k = 0; k < n; k++)
						owe_beat(STAT_OK, 1'b1, slot_rule[k], k == n - 1);
					rules_listed += n;
				end
			end
			default: begin
				owe_beat(STAT_OK, 1'b0, '0, 1'b1);
			end
		endcase
		if (held > peak_rules)
			peak_rules = held;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rule_t            req_rule;
		logic [LIMIT_W-1:0] req_limit;
		beat_t            want;
		if (!arst_n) begin
			held           = 0;
			replies_due.delete();
			mismatches     = 0;
			replies_owed   = 0;
			requests_seen  = 0;
			beats_seen     = 0;
			rules_listed   = 0;
			dup_adds       = 0;
			full_adds      = 0;
			missed_deletes = 0;
			peak_rules     = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				req_rule.src_addr = s_tdata[31:0];
				req_rule.dst_addr = s_tdata[63:32];
				req_rule.sport    = s_tdata[79:64];
				req_rule.dport    = s_tdata[95:80];
				req_rule.protocol = s_tdata[103:96];
				req_limit         = s_tdata[109:104];
				requests_seen++;
				predict_reply(s_tuser, req_rule, req_limit);
			end
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (replies_due.size() == 0) begin
					$error("result beat with nothing owed: tdata %0h", m_tdata);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
					check_field("rule_count", 32'(want.rule_count), 32'(m_tdata[7:2]));
					check_field("entry_valid", 32'(want.entry_valid), 32'(m_tuser));
					check_field("out_src_addr", want.rule.src_addr, m_tdata[39:8]);
					check_field("out_dst_addr", want.rule.dst_addr, m_tdata[71:40]);
					check_field("listed source port", 32'(want.rule.sport),
							32'(m_tdata[87:72]));
					check_field("listed destination port", 32'(want.rule.dport),
							32'(m_tdata[103:88]));
					check_field("out_protocol", 32'(want.rule.protocol),
							32'(m_tdata[111:104]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			replies_owed = replies_due.size();
		end
	end

endmodule

// ===== tb/sv/five_tuple_rule_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// five_tuple_rule_table_test
// Drives add, delete and list requests into the rule table with random gaps
// and output stalls: a directed opening over the corner cases, then phases
// that grow, shrink and churn the table, and a quiet stretch at the end.
// ----------------------------------------------------------------------------

module five_tuple_rule_table_test;
	import ftrt_pkg::*;

	localparam int TABLE_SLOTS  = DEF_RULE_SLOTS;
	localparam int RANDOM_ITEMS = 370;
	localparam int QUIET_ITEMS  = 60;
	localparam int CYCLE_LIMIT  = 800_000;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum {GROW, SHRINK, CHURN} mix_e;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// source address, destination address, source port, destination port,
	// protocol, list limit, zero pad
	logic [S_TDATA_W-1:0] s_tdata;
	// req_type
	logic [REQ_W-1:0]     s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// status, rule count, listed source address, destination address,
	// source port, destination port, protocol
	logic [M_TDATA_W-1:0] m_tdata;
	// entry_valid
	logic                 m_tuser;
	logic                 m_tlast;

	int mismatches, replies_owed, requests_seen, beats_seen, rules_listed;
	int dup_adds, full_adds, missed_deletes, peak_rules;

	bit    gaps_on = 1'b1;
	int    cycle_count = 0;
	rule_t live_rules [$];

	five_tuple_rule_table #(
		.RULE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	five_tuple_rule_table_checker #(
		.RULE_SLOTS(TABLE_SLOTS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.replies_owed   (replies_owed),
		.requests_seen  (requests_seen),
		.beats_seen     (beats_seen),
		.rules_listed   (rules_listed),
		.dup_adds       (dup_adds),
		.full_adds      (full_adds),
		.missed_deletes (missed_deletes),
		.peak_rules     (peak_rules)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("five_tuple_rule_table regression: fail");
			$finish;
		end
	end

	// Output stalls come in bursts; once gaps are off the sink always takes.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	function automatic rule_t make_rule(input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] pr);
		rule_t r;
		r.src_addr = sa;
		r.dst_addr = da;
		r.sport    = sp;
		r.dport    = dp;
		r.protocol = pr;
		return r;
	endfunction

	function automatic bit is_live(input rule_t r);
		foreach (live_rules[i])
			if (live_rules[i] == r)
				return 1'b1;
		return 1'b0;
	endfunction

	// Mostly random, with a bias toward all-zero and all-one fields.
	function automatic logic [31:0] field_value(input int bits);
		logic [63:0] mask;
		mask = (64'd1 << bits) - 64'd1;
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return mask[31:0];
			default: return $urandom & mask[31:0];
		endcase
	endfunction

	// A rule not currently stored; often a one-bit neighbor of a stored one.
	function automatic rule_t fresh_rule();
		rule_t r;
		do begin
			if (live_rules.size() > 0 && $urandom_range(0, 2) == 0) begin
				r = live_rules[$urandom_range(0, live_rules.size() - 1)];
				case ($urandom_range(0, 4))
					0: r.src_addr[$urandom_range(0, 31)] ^= 1'b1;
					1: r.dst_addr[$urandom_range(0, 31)] ^= 1'b1;
					2: r.sport[$urandom_range(0, 15)] ^= 1'b1;
					3: r.dport[$urandom_range(0, 15)] ^= 1'b1;
					default: r.protocol[$urandom_range(0, 7)] ^= 1'b1;
				endcase
			end else begin
				r = make_rule(field_value(32), field_value(32), 16'(field_value(16)),
						16'(field_value(16)), 8'(field_value(8)));
			end
		end while (is_live(r));
		return r;
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] kind, input rule_t r,
			input logic [LIMIT_W-1:0] lim);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, lim, r.protocol, r.dport, r.sport, r.dst_addr,
				r.src_addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic hold_until_answered();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (replies_owed != 0) @(negedge clk);
	endtask

	task automatic add_fresh();
		rule_t r;
		r = fresh_rule();
		send_request(REQ_ADD, r, '0);
		if (live_rules.size() < TABLE_SLOTS)
			live_rules.push_back(r);
	endtask

	task automatic add_repeat();
		if (live_rules.size() == 0)
			add_fresh();
		else
			send_request(REQ_ADD, live_rules[$urandom_range(0, live_rules.size() - 1)], '0);
	endtask

	task automatic drop_absent();
		send_request(REQ_DEL, fresh_rule(), '0);
	endtask

	task automatic drop_live();
		int    idx;
		rule_t r;
		if (live_rules.size() == 0) begin
			drop_absent();
		end else begin
			idx = $urandom_range(0, live_rules.size() - 1);
			r   = live_rules[idx];
			live_rules.delete(idx);
			send_request(REQ_DEL, r, '0);
		end
	endtask

	task automatic list_some();
		logic [LIMIT_W-1:0] lim;
		case ($urandom_range(0, 5))
			0:       lim = '0;
			1:       lim = LIMIT_W'(TABLE_SLOTS);
			default: lim = LIMIT_W'($urandom_range(1, TABLE_SLOTS));
		endcase
		send_request(REQ_LIST, fresh_rule(), lim);
	endtask

	task automatic random_request(input mix_e mix);
		int p;
		p = $urandom_range(0, 99);
		case (mix)
			GROW: begin
				if (p < 70)      add_fresh();
				else if (p < 80) add_repeat();
				else if (p < 90) list_some();
				else             drop_live();
			end
			SHRINK: begin
				if (p < 60)      drop_live();
				else if (p < 70) drop_absent();
				else if (p < 85) list_some();
				else if (p < 95) add_fresh();
				else             add_repeat();
			end
			default: begin
				if (p < 30)      add_fresh();
				else if (p < 40) add_repeat();
				else if (p < 65) drop_live();
				else if (p < 75) drop_absent();
				else if (p < 98) list_some();
				else             send_request(REQ_UNUSED, fresh_rule(), 6'h3f);
			end
		endcase
	endtask

	initial begin : stimulus
		rule_t zero_rule, ones_rule, near_rule, mixed_rule;
		mix_e  mix;
		int    sent;
		int    round;
		int    span;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		zero_rule  = make_rule(32'h0, 32'h0, 16'h0, 16'h0, 8'h0);
		ones_rule  = make_rule(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 8'hff);
		near_rule  = make_rule(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 8'hfe);
		mixed_rule = make_rule(32'hc0a8_0001, 32'h0a00_00fe, 16'd443, 16'd51234, 8'd6);

		// Corner cases: empty table, extremes, near misses and the slot move.
		send_request(REQ_LIST, zero_rule, 6'd32);
		send_request(REQ_DEL, ones_rule, '0);
		send_request(REQ_ADD, zero_rule, '0);
		send_request(REQ_ADD, ones_rule, '0);
		send_request(REQ_ADD, ones_rule, '0);
		send_request(REQ_ADD, near_rule, 6'h3f);
		send_request(REQ_ADD, mixed_rule, '0);
		send_request(REQ_LIST, ones_rule, 6'd0);
		send_request(REQ_LIST, zero_rule, 6'd1);
		send_request(REQ_LIST, zero_rule, 6'd32);
		send_request(REQ_UNUSED, zero_rule, '0);
		send_request(REQ_DEL, make_rule(32'hffff_ffff, 32'hffff_ffff, 16'hfffe, 16'hffff,
				8'hff), '0);
		send_request(REQ_DEL, zero_rule, '0);
		send_request(REQ_LIST, zero_rule, 6'd32);
		send_request(REQ_DEL, mixed_rule, '0);
		send_request(REQ_LIST, zero_rule, 6'd31);
		send_request(REQ_DEL, ones_rule, '0);
		send_request(REQ_DEL, ones_rule, '0);
		send_request(REQ_DEL, near_rule, '0);
		send_request(REQ_LIST, zero_rule, 6'd32);
		send_request(REQ_UNUSED, ones_rule, 6'h3f);
		hold_until_answered();

		// The first phase fills the table so that full and duplicate-when-full
		// cases come up early; later phases are picked at random.
		sent  = 0;
		round = 0;
		while (sent < RANDOM_ITEMS) begin
			mix  = (round == 0) ? GROW : mix_e'($urandom_range(0, 2));
			span = (round == 0) ? 50 : $urandom_range(20, 45);
			for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
				if (sent == RANDOM_ITEMS - QUIET_ITEMS)
					gaps_on = 1'b0;
				random_request(mix);
				sent++;
			end
			if (gaps_on && $urandom_range(0, 3) == 0)
				hold_until_answered();
			round++;
		end

		hold_until_answered();
		repeat (40) @(negedge clk);

		$display("Ran %0d requests and checked %0d result beats, %0d of which listed rules.",
				requests_seen, beats_seen, rules_listed);
		$display("Duplicate adds %0d, adds to a full table %0d, missed deletes %0d,",
				dup_adds, full_adds, missed_deletes);
		$display("and the table peaked at %0d rules.", peak_rules);
		if (mismatches == 0 && replies_owed == 0) begin
			$display("five_tuple_rule_table regression: pass");
		end else begin
			$display("five_tuple_rule_table regression: fail");
		end
		$finish;
	end

endmodule
